// File: hw/rtl/tsb_pkg.sv
// Shared constants, types and helpers for the transformed sphere bounds block.
// Used by tsb_isqrt and transformed_sphere_bounds; depends on nothing.
`timescale 1ns / 1ps

package tsb_pkg;

    localparam int FRAC_BITS  = 16;            // Q fraction bits (8..24)
    localparam int VAL_W      = 32;            // signed fixed-point value
    localparam int RAD_W      = 31;            // unsigned radius
    localparam int OP_W       = VAL_W + 1;     // shared multiplier operand
    localparam int PROD_W     = 2 * OP_W;      // multiplier product
    localparam int WIDE_W     = PROD_W + 1;    // shifted sum plus offset
    localparam int SQ_W       = 64;            // square root radicand
    localparam int ROOT_W     = SQ_W / 2 + 1;  // root, up to 2^32
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int STEP_W     = $clog2(SQRT_STEPS);

    localparam logic [RAD_W-1:0] Q_ONE   = RAD_W'(64'(1) << FRAC_BITS);
    localparam logic [RAD_W-1:0] Q_TENTH = RAD_W'(((64'(1) << FRAC_BITS) + 5) / 10);
    localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

    localparam logic signed [WIDE_W-1:0] VAL_MAX_W = WIDE_W'(64'sd2147483647);
    localparam logic signed [WIDE_W-1:0] VAL_MIN_W = WIDE_W'(-64'sd2147483648);

    typedef logic signed [VAL_W-1:0] t_val;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] value;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

    // Clamp a wide signed value into the signed 32-bit range.
    function automatic t_val sat_val(input logic signed [WIDE_W-1:0] v);
        t_val r;
        if (v > VAL_MAX_W) begin
            r = VAL_MAX_W[VAL_W-1:0];
        end else if (v < VAL_MIN_W) begin
            r = VAL_MIN_W[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/tsb_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on tsb_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module tsb_isqrt import tsb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sqrt_req i_req,
    output t_sqrt_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_k;
    logic [SQ_W-1:0]   r_n;
    logic [SQ_W-1:0]   r_r;

    logic [SQ_W-1:0]   w_bit;
    logic [SQ_W:0]     w_trial;
    logic              w_fit;

    // bit = 4^k
    assign w_bit   = SQ_W'(1) << {r_k, 1'b0};
    assign w_trial = {1'b0, r_r} + {1'b0, w_bit};
    assign w_fit   = {1'b0, r_n} >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_n    <= i_req.value;
                r_r    <= '0;
                r_k    <= STEP_W'(SQRT_STEPS - 1);
            end else if (r_busy) begin
                if (w_fit) begin
                    r_n <= r_n - w_trial[SQ_W-1:0];
                    r_r <= (r_r >> 1) + w_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                if (r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_r[ROOT_W-1:0];

endmodule

// File: hw/rtl/transformed_sphere_bounds.sv
// Scene bounding sphere from per-axis rows of transformed model cubes.
// A folding item runs multiply, drain, fold and update; the last item of a
// pass then adds three squares and a 32-step root before its result shows.
// Throughput: one item at a time, set by the single shared 33x33 multiplier
// and the iterative root unit. Synchronous active-low reset clears the state.
`timescale 1ns / 1ps

module transformed_sphere_bounds import tsb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] coef_x, [63:32] coef_y, [95:64] coef_z, [127:96] row_offset,
    // [159:128] model_center_x, [191:160] model_center_y,
    // [223:192] model_center_z, [254:224] model_radius, [255] zero
    input  logic [255:0] s_axis_tdata,
    // [1:0] axis, [2] present
    input  logic [2:0]   s_axis_tuser,
    input  logic         s_axis_tlast,   // last_item
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] bounds_center_x, [63:32] bounds_center_y,
    // [95:64] bounds_center_z, [126:96] bounds_radius, [127] zero
    output logic [127:0] m_axis_tdata,
    // [0] bounds_found
    output logic [0:0]   m_axis_tuser
);

    localparam logic [1:0] AXIS_NONE = 2'd3;   // unused axis code
    localparam logic [2:0] FOLD_LAST = 3'd5;   // six cube products per row
    localparam logic [2:0] SQ_LAST   = 3'd2;   // three squared extents

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,      // feed shared multiplier, one operand pair per cycle
        S_DRAIN,    // let products reach the accumulators
        S_FOLD,     // shift, add offset, saturate
        S_UPDATE,   // merge into running min/max
        S_DECIDE,   // last item: any bounds seen?
        S_SQRT,     // kick off root
        S_WAIT,     // wait for root
        S_EMIT      // load output register, clear pass state
    } t_state;

    t_state             r_state;

    // captured item
    logic [1:0]         r_axis;
    logic               r_last;
    t_val               r_coef [3];
    t_val               r_ctr  [3];
    t_val               r_offset;
    logic [RAD_W-1:0]   r_radius;

    // sequencer and shared multiplier pipeline
    logic [2:0]         r_cnt;
    logic               r_sq_phase;
    logic               r_op_vld;
    logic               r_op_tag;      // 1: product goes to the max sum
    logic signed [OP_W-1:0]   r_op_a;
    logic signed [OP_W-1:0]   r_op_b;
    logic signed [PROD_W-1:0] r_prod;
    logic               r_prod_vld;
    logic               r_prod_tag;
    logic [PROD_W-1:0]  r_acc_lo;      // also sums the squares
    logic [PROD_W-1:0]  r_acc_hi;
    t_val               r_vlo;
    t_val               r_vhi;

    // pass state
    t_val               r_min [3];
    t_val               r_max [3];
    logic [2:0]         r_seen;

    // output register
    logic               r_m_valid;
    logic [127:0]       r_m_data;
    logic               r_m_found;

    t_sqrt_req          w_sqrt_req;
    t_sqrt_rsp          w_sqrt_rsp;

    logic               w_accept;
    logic               w_out_free;
    t_val               w_coef;
    t_val               w_ctr;
    logic signed [VAL_W:0] w_lo_wide;
    logic signed [VAL_W:0] w_hi_wide;
    t_val               w_lo;
    t_val               w_hi;
    logic               w_use_hi;
    t_val               w_dmin;
    t_val               w_dmax;
    logic [VAL_W:0]     w_d_wide;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [WIDE_W-1:0] w_lo_sum;
    logic signed [WIDE_W-1:0] w_hi_sum;
    t_val               w_center [3];
    logic [RAD_W-1:0]   w_radius;
    logic               w_found;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_found    = |r_seen;

    // Operands: term cnt[2:1], cnt[0] min or max; squared axis cnt[1:0].
    always_comb begin
        case (r_cnt[2:1])
            2'd0:    begin w_coef = r_coef[0]; w_ctr = r_ctr[0]; end
            2'd1:    begin w_coef = r_coef[1]; w_ctr = r_ctr[1]; end
            2'd2:    begin w_coef = r_coef[2]; w_ctr = r_ctr[2]; end
            default: begin w_coef = r_coef[0]; w_ctr = r_ctr[0]; end
        endcase
        case (r_cnt[1:0])
            2'd0:    begin w_dmin = r_min[0]; w_dmax = r_max[0]; end
            2'd1:    begin w_dmin = r_min[1]; w_dmax = r_max[1]; end
            2'd2:    begin w_dmin = r_min[2]; w_dmax = r_max[2]; end
            default: begin w_dmin = r_min[0]; w_dmax = r_max[0]; end
        endcase
    end

    assign w_lo_wide = (VAL_W+1)'(w_ctr) - $signed({2'b00, r_radius});
    assign w_hi_wide = (VAL_W+1)'(w_ctr) + $signed({2'b00, r_radius});
    assign w_lo      = sat_val(WIDE_W'(w_lo_wide));
    assign w_hi      = sat_val(WIDE_W'(w_hi_wide));
    // negative coefficient swaps which cube end gives the min product
    assign w_use_hi  = r_cnt[0] ^ w_coef[VAL_W-1];
    // max >= min on every axis, so the extent fits 32 bits unsigned
    assign w_d_wide  = (VAL_W+1)'(w_dmax) - (VAL_W+1)'(w_dmin);

    assign w_prod    = r_op_a * r_op_b;

    // exact floor of the product sum, then the row offset
    assign w_lo_sum  = WIDE_W'($signed(r_acc_lo) >>> FRAC_BITS) + WIDE_W'(r_offset);
    assign w_hi_sum  = WIDE_W'($signed(r_acc_hi) >>> FRAC_BITS) + WIDE_W'(r_offset);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_center[k] = t_val'(((VAL_W+1)'(r_min[k]) + (VAL_W+1)'(r_max[k])) >>> 1);
        end
        if (w_sqrt_rsp.root > ROOT_W'(RAD_MAX)) begin
            w_radius = RAD_MAX;
        end else if (w_sqrt_rsp.root < ROOT_W'(Q_TENTH)) begin
            w_radius = Q_TENTH;
        end else begin
            w_radius = w_sqrt_rsp.root[RAD_W-1:0];
        end
    end

    // radicand is floor(sum of squares / 4)
    assign w_sqrt_req.start = (r_state == S_SQRT);
    assign w_sqrt_req.value = r_acc_lo[PROD_W-1:2];

    tsb_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_sqrt_req),
        .o_rsp   (w_sqrt_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_op_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            r_seen     <= '0;
            r_m_valid  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_min[k] <= '0;
                r_max[k] <= '0;
            end
        end else begin
            // shared multiplier pipeline: operands -> product -> accumulate
            r_op_vld   <= 1'b0;
            r_prod     <= w_prod;
            r_prod_vld <= r_op_vld;
            r_prod_tag <= r_op_tag;
            if (r_prod_vld) begin
                if (r_prod_tag) begin
                    r_acc_hi <= r_acc_hi + r_prod;
                end else begin
                    r_acc_lo <= r_acc_lo + r_prod;
                end
            end

            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_axis    <= s_axis_tuser[1:0];
                        r_last    <= s_axis_tlast;
                        r_coef[0] <= s_axis_tdata[31:0];
                        r_coef[1] <= s_axis_tdata[63:32];
                        r_coef[2] <= s_axis_tdata[95:64];
                        r_offset  <= s_axis_tdata[127:96];
                        r_ctr[0]  <= s_axis_tdata[159:128];
                        r_ctr[1]  <= s_axis_tdata[191:160];
                        r_ctr[2]  <= s_axis_tdata[223:192];
                        r_radius  <= s_axis_tdata[254:224];
                        r_cnt      <= '0;
                        r_sq_phase <= 1'b0;
                        r_acc_lo   <= '0;
                        r_acc_hi   <= '0;
                        if (s_axis_tuser[2] && (s_axis_tuser[1:0] != AXIS_NONE)) begin
                            r_state <= S_MUL;
                        end else if (s_axis_tlast) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_MUL: begin
                    r_op_vld <= 1'b1;
                    if (r_sq_phase) begin
                        r_op_a   <= $signed({1'b0, w_d_wide[VAL_W-1:0]});
                        r_op_b   <= $signed({1'b0, w_d_wide[VAL_W-1:0]});
                        r_op_tag <= 1'b0;
                    end else begin
                        r_op_a   <= OP_W'(w_coef);
                        r_op_b   <= w_use_hi ? OP_W'(w_hi) : OP_W'(w_lo);
                        r_op_tag <= r_cnt[0];
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (r_sq_phase ? SQ_LAST : FOLD_LAST)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_op_vld && !r_prod_vld) begin
                        r_state <= r_sq_phase ? S_SQRT : S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_vlo   <= sat_val(w_lo_sum);
                    r_vhi   <= sat_val(w_hi_sum);
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (!r_seen[r_axis]) begin
                        r_min[r_axis]  <= r_vlo;
                        r_max[r_axis]  <= r_vhi;
                        r_seen[r_axis] <= 1'b1;
                    end else begin
                        if (r_vlo < r_min[r_axis]) r_min[r_axis] <= r_vlo;
                        if (r_vhi > r_max[r_axis]) r_max[r_axis] <= r_vhi;
                    end
                    r_state <= r_last ? S_DECIDE : S_IDLE;
                end
                S_DECIDE: begin
                    r_cnt      <= '0;
                    r_sq_phase <= 1'b1;
                    r_acc_lo   <= '0;
                    r_state    <= w_found ? S_MUL : S_EMIT;
                end
                S_SQRT: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_sqrt_rsp.done) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_found <= w_found;
                        if (w_found) begin
                            r_m_data <= {1'b0, w_radius, w_center[2], w_center[1], w_center[0]};
                        end else begin
                            r_m_data <= {1'b0, Q_ONE, {(3*VAL_W){1'b0}}};
                        end
                        // start the next pass from cleared bounds
                        r_seen <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_min[k] <= '0;
                            r_max[k] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_found;

    // a seen axis always holds an ordered interval
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_seen[0] || r_min[0] <= r_max[0]) && (!r_seen[1] || r_min[1] <= r_max[1]) &&
        (!r_seen[2] || r_min[2] <= r_max[2]))
        else $error("bounds interval inverted");

    // root unit only answers while the sequencer waits for it
    a_root_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_rsp.done |-> (r_state == S_WAIT))
        else $error("root result outside wait state");

    // empty pass reports the unit radius, a found pass at least the floor
    a_default_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[126:96] == Q_ONE))
        else $error("default radius wrong");

    a_radius_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[126:96] >= Q_TENTH))
        else $error("radius below floor");

    // products are drained before the fold reads the sums
    a_fold_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD || r_state == S_SQRT) |-> (!r_op_vld && !r_prod_vld))
        else $error("sum read while products in flight");

endmodule
